@@ hw/rtl/dcot_pkg.sv @@
// Package with shared constants and action codes for the depth/color occlusion test.
package dcot_pkg;

  // Default geometry of the color frame and the coarse depth map.
  localparam int QUANT_SHIFT_DEFAULT  = 2;
  localparam int COLOR_WIDTH_DEFAULT  = 1920;
  localparam int COLOR_HEIGHT_DEFAULT = 1080;

  // Field widths.
  localparam int DEPTH_W = 16;
  localparam int COORD_W = 13;
  localparam int INDEX_W = 21;

  // Width of the per-cell clear tag stored next to each depth cell.
  localparam int TAG_W = 8;

  // Threshold value after reset, in millimeters.
  localparam logic [DEPTH_W-1:0] THRESHOLD_RESET = 16'd100;

  // Input actions.
  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_RECORD = 2'd1;
  localparam logic [1:0] ACT_TEST   = 2'd2;

endpackage

@@ hw/rtl/depth_color_occlusion_test_core.sv @@
// Z-buffer occlusion test core: tagged depth-map memory, record and test logic.
// Flow: an accepted item is registered and evaluated, and a test result goes to the output
// register once it is free; the core takes no new item until the last is through, as the
// depth-map memory is read on accept and written back on evaluate; a test item waits longer
// while an earlier result still sits unaccepted in the output register.
// Reset: a clearing pass writes every map cell, one per cycle (129600 cells at the default
// frame size); the same pass runs on every 256th clear item, while no item is accepted.
module depth_color_occlusion_test_core
  import dcot_pkg::*;
#(
  parameter int QUANT_SHIFT  = QUANT_SHIFT_DEFAULT,
  parameter int COLOR_WIDTH  = COLOR_WIDTH_DEFAULT,
  parameter int COLOR_HEIGHT = COLOR_HEIGHT_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  // Configuration write channel.
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [DEPTH_W-1:0]        cfg_data,
  // Input item channel.
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                action,
  input  logic signed [COORD_W-1:0] color_x,
  input  logic signed [COORD_W-1:0] color_y,
  input  logic [DEPTH_W-1:0]        depth_mm,
  input  logic                      source_valid,
  // Result item channel.
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      visible,
  output logic [INDEX_W-1:0]        color_index
);

  localparam int CELL_SIZE = 1 << QUANT_SHIFT;
  localparam int MAP_W     = (COLOR_WIDTH + CELL_SIZE - 1) >> QUANT_SHIFT;
  localparam int MAP_H     = (COLOR_HEIGHT + CELL_SIZE - 1) >> QUANT_SHIFT;
  localparam int MAP_CELLS = MAP_W * MAP_H;
  localparam int ADDR_W    = $clog2(MAP_CELLS);
  localparam int UC_W      = COORD_W - 1;
  localparam int LIN_W     = 2 * UC_W;
  localparam int WORD_W    = TAG_W + DEPTH_W;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAP_CELLS - 1);

  // Controller states.
  localparam logic [1:0] ST_SWEEP = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EVAL  = 2'd2;

  logic [1:0]         state;
  logic [ADDR_W-1:0]  sweep_addr;
  logic [TAG_W-1:0]   epoch;
  logic [DEPTH_W-1:0] depth_threshold;

  // Registered item.
  logic [1:0]         act_q;
  logic [UC_W-1:0]    x_q;
  logic [UC_W-1:0]    y_q;
  logic [DEPTH_W-1:0] depth_q;
  logic               inside_q;
  logic               srcv_q;
  logic [ADDR_W-1:0]  addr_q;

  // Depth-map memory: each word holds a clear tag and the nearest depth.
  logic [WORD_W-1:0]  map_mem [MAP_CELLS];
  logic [WORD_W-1:0]  rd_data;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [WORD_W-1:0]  wr_data;

  logic               in_fire;
  logic               in_frame;
  logic [UC_W-1:0]    cx;
  logic [UC_W-1:0]    cy;
  logic [LIN_W-1:0]   cell_lin;
  logic [ADDR_W-1:0]  cell_addr;
  logic [DEPTH_W-1:0] cell_val;
  logic               rec_take;
  logic               pass;
  logic [LIN_W-1:0]   pix_lin;
  logic               out_free;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // Frame bounds and cell address of the incoming item.
  always_comb begin
    in_frame = !color_x[COORD_W-1] && !color_y[COORD_W-1]
            && (32'(color_x) < COLOR_WIDTH) && (32'(color_y) < COLOR_HEIGHT);
    cx = color_x[UC_W-1:0] >> QUANT_SHIFT;
    cy = color_y[UC_W-1:0] >> QUANT_SHIFT;
    cell_lin  = LIN_W'(cy) * LIN_W'(MAP_W) + LIN_W'(cx);
    cell_addr = in_frame ? cell_lin[ADDR_W-1:0] : '0;
  end

  // A cell whose tag is not the current epoch was cleared and reads as empty.
  always_comb begin
    cell_val = (rd_data[WORD_W-1:DEPTH_W] == epoch) ? rd_data[DEPTH_W-1:0] : '0;
    rec_take = inside_q && ((cell_val == '0) || (cell_val > depth_q));
    pass     = ({1'b0, depth_q} < ({1'b0, cell_val} + {1'b0, depth_threshold}));
    pix_lin  = LIN_W'(x_q) + LIN_W'(y_q) * LIN_W'(COLOR_WIDTH);
  end

  // Write port: the clearing pass or a record write-back.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = addr_q;
    wr_data = {epoch, depth_q};
    if (state == ST_SWEEP) begin
      wr_en   = 1'b1;
      wr_addr = sweep_addr;
      wr_data = '0;
    end else if ((state == ST_EVAL) && (act_q == ACT_RECORD) && rec_take) begin
      wr_en = 1'b1;
    end
  end

  // Memory with a registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
    if (in_fire) begin
      rd_data <= map_mem[cell_addr];
    end
  end

  // Capture of the accepted item.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_q    <= action;
      x_q      <= color_x[UC_W-1:0];
      y_q      <= color_y[UC_W-1:0];
      depth_q  <= depth_mm;
      inside_q <= in_frame;
      srcv_q   <= source_valid;
      addr_q   <= cell_addr;
    end
  end

  // Threshold register.
  always_ff @(posedge clk) begin
    if (rst) begin
      depth_threshold <= THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      depth_threshold <= cfg_data;
    end
  end

  // Controller: clearing pass, accept, evaluate.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_SWEEP;
      sweep_addr <= '0;
      epoch      <= '0;
    end else begin
      unique case (state)
        ST_SWEEP: begin
          if (sweep_addr == LAST_ADDR) begin
            state <= ST_IDLE;
          end
          sweep_addr <= sweep_addr + 1'b1;
        end
        ST_IDLE: begin
          if (in_fire) begin
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          case (act_q)
            ACT_CLEAR: begin
              // Tags run out: rewrite the whole map and restart the epoch.
              if (epoch == '1) begin
                state      <= ST_SWEEP;
                sweep_addr <= '0;
                epoch      <= '0;
              end else begin
                state <= ST_IDLE;
                epoch <= epoch + 1'b1;
              end
            end
            ACT_TEST: begin
              if (out_free) begin
                state <= ST_IDLE;
              end
            end
            default: begin
              state <= ST_IDLE;
            end
          endcase
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register for test results.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_EVAL) && (act_q == ACT_TEST) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_EVAL) && (act_q == ACT_TEST) && out_free) begin
      visible     <= srcv_q && inside_q && pass;
      color_index <= (srcv_q && inside_q && pass) ? pix_lin[INDEX_W-1:0] : '0;
    end
  end

`ifndef SYNTHESIS
  // An accepted item is evaluated in the next cycle.
  a_accept_eval: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == ST_EVAL)
    else $error("accepted item not evaluated");

  // No item is taken while the map is being cleared.
  a_sweep_block: assert property (@(posedge clk) disable iff (rst)
    state == ST_SWEEP |-> !in_ready)
    else $error("item accepted during clearing pass");

  // A hidden pixel reports index zero.
  a_hidden_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !visible |-> color_index == '0)
    else $error("hidden pixel with nonzero index");
`endif

endmodule
